[sv/aaq_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, fixed-point constants and the CORDIC arctangent table
// for the axis-angle to quaternion converter. No dependencies.
package aaq_pkg;

   localparam int AXES    = 3;
   localparam int COMP_W  = 16;   // Q3.12 input component
   localparam int QUAT_W  = 16;   // Q1.14 output part
   localparam int THR_W   = 13;
   localparam int SQ_W    = 31;   // one squared component
   localparam int SUM_W   = 32;   // sum of three squares
   localparam int RAD_W   = 40;   // sum scaled by 256 for the Q.16 root
   localparam int NORM_W  = 20;   // Q.16 norm
   localparam int ANG_W   = 35;   // half angle before reduction, Q.30
   localparam int Z_W     = 34;   // reduced angle, Q.30
   localparam int XY_W    = 34;   // CORDIC vector, Q.30
   localparam int PROD_W  = 50;   // component times sine
   localparam int DEN_W   = 32;   // norm16 * 2^12
   localparam int QUO_W   = 16;
   localparam int ATAN_N  = 24;

   localparam logic signed [QUAT_W-1:0] Q_ONE = 16'sd16384;

   localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
   localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;

   function automatic logic [31:0] atan_q30(input int idx);
      logic [31:0] v;
      case (idx)
         0:  v = 32'd843314856;
         1:  v = 32'd497837829;
         2:  v = 32'd263043836;
         3:  v = 32'd133525158;
         4:  v = 32'd67021686;
         5:  v = 32'd33543515;
         6:  v = 32'd16775850;
         7:  v = 32'd8388437;
         8:  v = 32'd4194282;
         9:  v = 32'd2097149;
         10: v = 32'd1048575;
         11: v = 32'd524288;
         12: v = 32'd262144;
         13: v = 32'd131072;
         14: v = 32'd65536;
         15: v = 32'd32768;
         16: v = 32'd16384;
         17: v = 32'd8192;
         18: v = 32'd4096;
         19: v = 32'd2048;
         20: v = 32'd1024;
         21: v = 32'd512;
         22: v = 32'd256;
         23: v = 32'd128;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

[sv/axis_angle_to_quaternion.sv]
`timescale 1ns / 1ps
// Top level: rotation vector (Q3.12) to unit quaternion (Q1.14).
// Depends on aaq_pkg, aaq_sqrt, aaq_cordic and aaq_div.
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall  rot_x, rot_y, rot_z
//   rsp_     out        rsp_valid/rsp_stall  quat_x, quat_y, quat_z, quat_w
//   csr_     in         csr_valid/csr_ready  small_norm_threshold
//
// One word per cycle sustained while rsp_stall does not hold the pipe.
// Synchronous active-high reset clears the valid bits and the threshold.
// A held word on rsp_ freezes the whole pipe; gaps between words are kept.
module axis_angle_to_quaternion #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [aaq_pkg::COMP_W-1:0]   req_rot_x,
   input  logic signed [aaq_pkg::COMP_W-1:0]   req_rot_y,
   input  logic signed [aaq_pkg::COMP_W-1:0]   req_rot_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [aaq_pkg::QUAT_W-1:0]   rsp_quat_x,
   output logic signed [aaq_pkg::QUAT_W-1:0]   rsp_quat_y,
   output logic signed [aaq_pkg::QUAT_W-1:0]   rsp_quat_z,
   output logic signed [aaq_pkg::QUAT_W-1:0]   rsp_quat_w,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [aaq_pkg::THR_W-1:0]           csr_data
);
   import aaq_pkg::*;

   localparam int R_W     = AXES * COMP_W;
   localparam int CSIDE_W = 2 + NORM_W + R_W;       // identity, neg, norm, r
   localparam int DSIDE_W = 1 + AXES + XY_W;        // identity, signs, cos

   logic en;
   logic [THR_W-1:0] thr_ff;

   // the pipe moves whenever the output register can take a word
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // input register, then squares
   logic                             va_ff, vb_ff;
   logic signed [AXES-1:0][COMP_W-1:0] ra_ff, rb_ff;
   logic [AXES-1:0][SQ_W-1:0]        sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [2*COMP_W-1:0] p;
      if (en) begin
         ra_ff <= {req_rot_z, req_rot_y, req_rot_x};
         rb_ff <= ra_ff;
         for (int a = 0; a < AXES; a++) begin
            p = $signed(ra_ff[a]) * $signed(ra_ff[a]);
            sq_ff[a] <= p[SQ_W-1:0];
         end
      end
   end

   logic [SUM_W-1:0] sum;
   assign sum = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);

   logic              sq_valid;
   logic [NORM_W-1:0] norm16;
   logic [R_W-1:0]    sq_r;

   aaq_sqrt #(.SIDE_W(R_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vb_ff),
      .in_rad    ({sum, 8'd0}),
      .in_side   (rb_ff),
      .out_valid (sq_valid),
      .out_root  (norm16),
      .out_side  (sq_r)
   );

   // threshold test and half-angle reduction into [-pi/2, pi/2]
   logic                     identity, neg;
   logic signed [ANG_W-1:0]  ang, ang1, ang2;

   always_comb begin
      identity = norm16[NORM_W-1:4] <= (NORM_W-4)'(thr_ff);
      ang  = $signed(ANG_W'(norm16) << 13);
      ang1 = (ang > PI_Q30) ? ang - TWO_PI_Q30 : ang;
      neg  = 1'b0;
      ang2 = ang1;
      if (ang1 > HALF_PI_Q30) begin
         ang2 = ang1 - PI_Q30;
         neg  = 1'b1;
      end else if (ang1 < -HALF_PI_Q30) begin
         ang2 = ang1 + PI_Q30;
         neg  = 1'b1;
      end
   end

   logic                   co_valid;
   logic signed [XY_W-1:0] co_x, co_y;
   logic [CSIDE_W-1:0]     co_side;

   aaq_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(CSIDE_W)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_angle  (ang2[Z_W-1:0]),
      .in_side   ({identity, neg, norm16, sq_r}),
      .out_valid (co_valid),
      .out_cos   (co_x),
      .out_sin   (co_y),
      .out_side  (co_side)
   );

   // sign fix-up of sine and cosine
   logic                     ve_ff, ide_ff;
   logic signed [XY_W-1:0]   cos_e_ff, sin_e_ff;
   logic [NORM_W-1:0]        norm_e_ff;
   logic signed [AXES-1:0][COMP_W-1:0] r_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (en) begin
         ve_ff <= co_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ide_ff    <= co_side[CSIDE_W-1];
         cos_e_ff  <= co_side[CSIDE_W-2] ? -co_x : co_x;
         sin_e_ff  <= co_side[CSIDE_W-2] ? -co_y : co_y;
         norm_e_ff <= co_side[R_W +: NORM_W];
         r_e_ff    <= co_side[R_W-1:0];
      end
   end

   // component times sine, kept as magnitude and sign
   logic                      vf_ff, idf_ff;
   logic [AXES-1:0][PROD_W-1:0] mag_f_ff;
   logic [AXES-1:0]           sgn_f_ff;
   logic signed [XY_W-1:0]    cos_f_ff;
   logic [NORM_W-1:0]         norm_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else if (en) begin
         vf_ff <= ve_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [PROD_W-1:0] p;
      if (en) begin
         for (int a = 0; a < AXES; a++) begin
            // lane selects of a packed array are unsigned, so re-sign first
            p = PROD_W'($signed(r_e_ff[a])) * PROD_W'(sin_e_ff);
            mag_f_ff[a] <= p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
            sgn_f_ff[a] <= p[PROD_W-1];
         end
         idf_ff    <= ide_ff;
         cos_f_ff  <= cos_e_ff;
         norm_f_ff <= norm_e_ff;
      end
   end

   // round half away from zero: add half the divisor to the magnitude
   logic [DEN_W-1:0]            den;
   logic [AXES-1:0][PROD_W-1:0] num_rnd;

   always_comb begin
      den = DEN_W'(norm_f_ff) << 12;
      for (int a = 0; a < AXES; a++)
         num_rnd[a] = mag_f_ff[a] + PROD_W'(den >> 1);
   end

   logic                       dv_valid;
   logic [AXES-1:0][QUO_W-1:0] quo;
   logic [DSIDE_W-1:0]         dv_side;

   aaq_div #(.SIDE_W(DSIDE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vf_ff),
      .in_num    (num_rnd),
      .in_den    (den),
      .in_side   ({idf_ff, sgn_f_ff, cos_f_ff}),
      .out_valid (dv_valid),
      .out_quo   (quo),
      .out_side  (dv_side)
   );

   // saturation and output register
   logic                     dv_id;
   logic [AXES-1:0]          dv_sgn;
   logic signed [XY_W-1:0]   dv_cos;
   logic signed [XY_W-1:0]   w_sum;
   logic signed [XY_W-17:0]  w_sh;
   logic signed [QUAT_W-1:0] w_sat;
   logic signed [AXES-1:0][QUAT_W-1:0] v_sat;

   always_comb begin
      logic [QUO_W-1:0] m;
      dv_id  = dv_side[DSIDE_W-1];
      dv_sgn = dv_side[XY_W +: AXES];
      dv_cos = dv_side[XY_W-1:0];
      w_sum  = dv_cos + XY_W'(32768);
      w_sh   = w_sum[XY_W-1:16];
      if (w_sh > (XY_W-16)'(Q_ONE))       w_sat = Q_ONE;
      else if (w_sh < -(XY_W-16)'(Q_ONE)) w_sat = -Q_ONE;
      else                                w_sat = w_sh[QUAT_W-1:0];
      for (int a = 0; a < AXES; a++) begin
         m = (quo[a] > QUO_W'(Q_ONE)) ? QUO_W'(Q_ONE) : quo[a];
         v_sat[a] = dv_sgn[a] ? -$signed(m) : $signed(m);
      end
      if (dv_id) begin
         w_sat = Q_ONE;
         v_sat = '0;
      end
   end

   logic                      rsp_valid_ff;
   logic signed [QUAT_W-1:0]  qx_ff, qy_ff, qz_ff, qw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qx_ff <= v_sat[0];
         qy_ff <= v_sat[1];
         qz_ff <= v_sat[2];
         qw_ff <= w_sat;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_x = qx_ff;
   assign rsp_quat_y = qy_ff;
   assign rsp_quat_z = qz_ff;
   assign rsp_quat_w = qw_ff;

endmodule

[sv/aaq_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
// Depends on aaq_pkg.
module aaq_sqrt #(
   parameter int SIDE_W = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [aaq_pkg::RAD_W-1:0]   in_rad,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [aaq_pkg::NORM_W-1:0]  out_root,
   output logic [SIDE_W-1:0]           out_side
);
   import aaq_pkg::*;

   localparam int REM_W = RAD_W + 1;

   logic              valid_ff [0:NORM_W];
   logic [REM_W-1:0]  rem_ff   [0:NORM_W];
   logic [NORM_W-1:0] root_ff  [0:NORM_W];
   logic [SIDE_W-1:0] side_ff  [0:NORM_W];
   logic [REM_W-1:0]  rem_in   [0:NORM_W-1];
   logic [NORM_W-1:0] root_in  [0:NORM_W-1];

   // stage j settles bit NORM_W-1-j: try (q + 2^b)^2 against the input
   always_comb begin
      logic [REM_W-1:0] trial;
      for (int j = 0; j < NORM_W; j++) begin
         trial = (REM_W'(root_ff[j]) << (NORM_W - j)) +
                 (REM_W'(1) << (2 * (NORM_W - 1 - j)));
         if (rem_ff[j] >= trial) begin
            rem_in[j]  = rem_ff[j] - trial;
            root_in[j] = root_ff[j] | (NORM_W'(1) << (NORM_W - 1 - j));
         end else begin
            rem_in[j]  = rem_ff[j];
            root_in[j] = root_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= NORM_W; j++) valid_ff[j] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int j = 0; j < NORM_W; j++) valid_ff[j+1] <= valid_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= REM_W'(in_rad);
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
         for (int j = 0; j < NORM_W; j++) begin
            rem_ff[j+1]  <= rem_in[j];
            root_ff[j+1] <= root_in[j];
            side_ff[j+1] <= side_ff[j];
         end
      end
   end

   assign out_valid = valid_ff[NORM_W];
   assign out_root  = root_ff[NORM_W];
   assign out_side  = side_ff[NORM_W];

endmodule

[sv/aaq_cordic.sv]
`timescale 1ns / 1ps
// Unrolled rotation-mode CORDIC, one micro-rotation per stage.
// Depends on aaq_pkg.
module aaq_cordic #(
   parameter int STEPS  = 16,
   parameter int SIDE_W = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic signed [aaq_pkg::Z_W-1:0]  in_angle,
   input  logic [SIDE_W-1:0]               in_side,
   output logic                            out_valid,
   output logic signed [aaq_pkg::XY_W-1:0] out_cos,
   output logic signed [aaq_pkg::XY_W-1:0] out_sin,
   output logic [SIDE_W-1:0]               out_side
);
   import aaq_pkg::*;

   logic                   valid_ff [0:STEPS];
   logic signed [XY_W-1:0] x_ff     [0:STEPS];
   logic signed [XY_W-1:0] y_ff     [0:STEPS];
   logic signed [Z_W-1:0]  z_ff     [0:STEPS];
   logic [SIDE_W-1:0]      side_ff  [0:STEPS];
   logic signed [XY_W-1:0] x_in     [0:STEPS-1];
   logic signed [XY_W-1:0] y_in     [0:STEPS-1];
   logic signed [Z_W-1:0]  z_in     [0:STEPS-1];

   always_comb begin
      logic signed [XY_W-1:0] dx, dy;
      logic signed [Z_W-1:0]  at;
      for (int i = 0; i < STEPS; i++) begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         at = $signed(Z_W'(atan_q30(i)));
         if (z_ff[i] >= 0) begin
            x_in[i] = x_ff[i] - dx;
            y_in[i] = y_ff[i] + dy;
            z_in[i] = z_ff[i] - at;
         end else begin
            x_in[i] = x_ff[i] + dx;
            y_in[i] = y_ff[i] - dy;
            z_in[i] = z_ff[i] + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= STEPS; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 0; i < STEPS; i++) valid_ff[i+1] <= valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= GAIN_Q30;
         y_ff[0]    <= '0;
         z_ff[0]    <= in_angle;
         side_ff[0] <= in_side;
         for (int i = 0; i < STEPS; i++) begin
            x_ff[i+1]    <= x_in[i];
            y_ff[i+1]    <= y_in[i];
            z_ff[i+1]    <= z_in[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_cos   = x_ff[STEPS];
   assign out_sin   = y_ff[STEPS];
   assign out_side  = side_ff[STEPS];

endmodule

[sv/aaq_div.sv]
`timescale 1ns / 1ps
// Three-lane pipelined restoring divider sharing one divisor,
// one quotient bit per stage. Depends on aaq_pkg.
module aaq_div #(
   parameter int SIDE_W = 8
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          en,
   input  logic                                          in_valid,
   input  logic [aaq_pkg::AXES-1:0][aaq_pkg::PROD_W-1:0] in_num,
   input  logic [aaq_pkg::DEN_W-1:0]                     in_den,
   input  logic [SIDE_W-1:0]                             in_side,
   output logic                                          out_valid,
   output logic [aaq_pkg::AXES-1:0][aaq_pkg::QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0]                             out_side
);
   import aaq_pkg::*;

   logic                               valid_ff [0:QUO_W];
   logic [AXES-1:0][PROD_W-1:0]        rem_ff   [0:QUO_W];
   logic [AXES-1:0][QUO_W-1:0]         quo_ff   [0:QUO_W];
   logic [DEN_W-1:0]                   den_ff   [0:QUO_W];
   logic [SIDE_W-1:0]                  side_ff  [0:QUO_W];
   logic [AXES-1:0][PROD_W-1:0]        rem_in   [0:QUO_W-1];
   logic [AXES-1:0][QUO_W-1:0]         quo_in   [0:QUO_W-1];

   always_comb begin
      logic [PROD_W-1:0] sub;
      for (int j = 0; j < QUO_W; j++) begin
         sub = PROD_W'(den_ff[j]) << (QUO_W - 1 - j);
         for (int a = 0; a < AXES; a++) begin
            if (rem_ff[j][a] >= sub) begin
               rem_in[j][a] = rem_ff[j][a] - sub;
               quo_in[j][a] = quo_ff[j][a] | (QUO_W'(1) << (QUO_W - 1 - j));
            end else begin
               rem_in[j][a] = rem_ff[j][a];
               quo_in[j][a] = quo_ff[j][a];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QUO_W; j++) valid_ff[j] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int j = 0; j < QUO_W; j++) valid_ff[j+1] <= valid_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= in_num;
         quo_ff[0]  <= '0;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int j = 0; j < QUO_W; j++) begin
            rem_ff[j+1]  <= rem_in[j];
            quo_ff[j+1]  <= quo_in[j];
            den_ff[j+1]  <= den_ff[j];
            side_ff[j+1] <= side_ff[j];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule
